FILE: rtl/ctg_pkg.sv
// constants, payload types and the divider step shared by the cubic trajectory generator
// no dependencies
package ctg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int WIDE_W    = 64;
   localparam int HALF_W    = WIDE_W / 2;
   localparam int SPAN_W    = DATA_W + 1;
   localparam int LAM_STEPS = DATA_W + FRAC_BITS;
   localparam int LAM_W     = LAM_STEPS + 2;
   localparam int LAM_HI_W  = LAM_W - HALF_W;
   localparam int VEL_STEPS = DATA_W;
   localparam int LL_W      = 2 * HALF_W + 2;
   localparam int LH_W      = HALF_W + 1 + LAM_HI_W;
   localparam int HL_W      = 2 * HALF_W + 1;
   localparam int HH_W      = HALF_W + LAM_HI_W;
   localparam int PROD_W    = WIDE_W + LAM_W;
   localparam int MID_W     = PROD_W - HALF_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_END_POSITION   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_START_VELOCITY = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_END_VELOCITY   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_END_TIME       = CSR_IDX_W'(5);

   localparam logic signed [DATA_W-1:0] END_TIME_RESET = DATA_W'(1 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] S64_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] S64_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] G_LIM = WIDE_W'(1) << (WIDE_W - 1 - FRAC_BITS);
   localparam logic [DATA_W:0] NEG_LIMIT = {2'b01, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic                    bypass;
      logic signed [LAM_W-1:0] lam;
      logic signed [WIDE_W-1:0] h;
      logic signed [WIDE_W-1:0] g;
      logic                    ovf;
   } ctg_side_type;

   typedef struct packed {
      logic bypass;
      logic neg;
   } ctg_lside_type;

   typedef struct packed {
      logic                     bypass;
      logic                     neg;
      logic                     big;
      logic signed [WIDE_W-1:0] h;
      logic                     ovf;
   } ctg_vside_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [DATA_W:0] div_step(input logic [DATA_W-1:0] rem,
                                                input logic nbit,
                                                input logic [DATA_W-1:0] dvsr);
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, dvsr};
      if (trial >= {1'b0, dvsr}) begin
         div_step = {1'b1, diff[DATA_W-1:0]};
      end else begin
         div_step = {1'b0, trial[DATA_W-1:0]};
      end
   endfunction

endpackage

FILE: rtl/cubic_trajectory_generator_top.sv
// cubic trajectory generator: one position and velocity word per time word
// depends on ctg_pkg and ctg_mac
//
// Each time word gives one result word; a new time word is taken every cycle unless the
// output stalls, and the result word passes through 109 register stages: one entry stage,
// 48 stages of the bit-serial lambda divider, one lambda stage, five multiply-add units
// of five stages each for the Horner chains, a velocity range stage, 32 stages of the
// velocity divider and the output register. The output register stalls the whole pipeline
// only while a result waits and rsp_ready is low. Coefficients are registered from the
// configuration words and follow a write through their own register chain; configuration
// is to be written only while no time word is in flight.
module cubic_trajectory_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ctg_pkg::DATA_W-1:0]    req_time_now,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ctg_pkg::DATA_W-1:0]    rsp_position,
   output logic signed [ctg_pkg::DATA_W-1:0]    rsp_velocity,
   output logic                                 rsp_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ctg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ctg_pkg::DATA_W-1:0]           csr_data
);
   import ctg_pkg::*;

   // configuration registers
   logic signed [DATA_W-1:0] cfg_start_position_ff, cfg_end_position_ff;
   logic signed [DATA_W-1:0] cfg_start_velocity_ff, cfg_end_velocity_ff;
   logic signed [DATA_W-1:0] cfg_start_time_ff, cfg_end_time_ff;

   // coefficient pipeline
   logic signed [SPAN_W-1:0] span_ff, dp_ff, vs_ff, dp1_ff, dp2_ff;
   logic signed [WIDE_W-1:0] a1_ff, a3p_ff, a3_ff, a1b_ff;
   logic signed [WIDE_W-1:0] a1c_ff, a2c_ff, a2x2_ff, a3c_ff, a3x3_ff;
   logic signed [DATA_W+SPAN_W-1:0] a1_full;
   logic signed [2*SPAN_W-1:0]      a3_full;
   logic signed [WIDE_W-1:0]        a2_c;
   logic [DATA_W-1:0]               span_u;

   logic en;
   logic accept;

   // lambda divider
   logic                 dv_vld_ff  [0:LAM_STEPS];
   ctg_lside_type        dv_side_ff [0:LAM_STEPS];
   logic [DATA_W-1:0]    dv_rem_ff  [0:LAM_STEPS];
   logic [LAM_STEPS-1:0] dv_num_ff  [0:LAM_STEPS];
   logic [DATA_W:0]      dv_step    [0:LAM_STEPS-1];
   logic signed [SPAN_W-1:0] d_in, d_abs;
   logic                     d_neg, bypass_in;

   logic                    lm_vld_ff;
   ctg_side_type            lm_side_ff;
   logic [LAM_W-1:0]        lam_mag;
   logic signed [LAM_W-1:0] lam_in;

   // horner chains
   logic                     mac_v  [0:5];
   ctg_side_type             mac_si [0:5];
   ctg_side_type             mac_so [0:4];
   logic signed [WIDE_W-1:0] mac_r  [0:4];
   logic                     mac_o  [0:4];
   logic signed [WIDE_W-1:0] p0_wide;

   // velocity divider
   logic              vd_vld_ff  [0:VEL_STEPS];
   ctg_vside_type     vd_side_ff [0:VEL_STEPS];
   logic [DATA_W-1:0] vd_rem_ff  [0:VEL_STEPS];
   logic [DATA_W-1:0] vd_num_ff  [0:VEL_STEPS];
   logic [DATA_W:0]   vd_step    [0:VEL_STEPS-1];
   logic signed [WIDE_W-1:0] vg;
   logic [WIDE_W-1:0]        vg_mag, vg_sh;
   logic                     vg_neg, vg_big;

   // output
   logic                     rsp_valid_ff, rsp_overflow_ff;
   logic signed [DATA_W-1:0] rsp_position_ff, rsp_velocity_ff;
   logic signed [DATA_W-1:0] pos_in, vel_in;
   logic                     ovf_in;
   logic [DATA_W:0]          vc, vc_neg;
   logic [DATA_W-1:0]        vq;
   ctg_vside_type            vo;

   assign csr_ready = 1'b1;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_position_ff <= '0;
         cfg_end_position_ff   <= '0;
         cfg_start_velocity_ff <= '0;
         cfg_end_velocity_ff   <= '0;
         cfg_start_time_ff     <= '0;
         cfg_end_time_ff       <= END_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_POSITION: cfg_start_position_ff <= csr_data;
            CSR_END_POSITION:   cfg_end_position_ff   <= csr_data;
            CSR_START_VELOCITY: cfg_start_velocity_ff <= csr_data;
            CSR_END_VELOCITY:   cfg_end_velocity_ff   <= csr_data;
            CSR_START_TIME:     cfg_start_time_ff     <= csr_data;
            CSR_END_TIME:       cfg_end_time_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // coefficients, free running from the configuration
   always_comb begin
      a1_full = cfg_start_velocity_ff * span_ff;
      a3_full = vs_ff * span_ff;
      a2_c    = WIDE_W'(dp2_ff) - a1b_ff - a3_ff;
      span_u  = span_ff[DATA_W-1:0];
      p0_wide = WIDE_W'(cfg_start_position_ff);
   end

   always_ff @(posedge clock) begin
      span_ff <= SPAN_W'(cfg_end_time_ff) - SPAN_W'(cfg_start_time_ff);
      dp_ff   <= SPAN_W'(cfg_end_position_ff) - SPAN_W'(cfg_start_position_ff);
      vs_ff   <= SPAN_W'(cfg_start_velocity_ff) + SPAN_W'(cfg_end_velocity_ff);
      a1_ff   <= WIDE_W'(a1_full >>> FRAC_BITS);
      a3p_ff  <= WIDE_W'(a3_full >>> FRAC_BITS);
      dp1_ff  <= dp_ff;
      a3_ff   <= a3p_ff - (WIDE_W'(dp1_ff) <<< 1);
      a1b_ff  <= a1_ff;
      dp2_ff  <= dp1_ff;
      a1c_ff  <= a1b_ff;
      a2c_ff  <= a2_c;
      a2x2_ff <= a2_c <<< 1;
      a3c_ff  <= a3_ff;
      a3x3_ff <= a3_ff + (a3_ff <<< 1);
   end

   // entry and lambda divider
   always_comb begin
      d_in      = SPAN_W'(req_time_now) - SPAN_W'(cfg_start_time_ff);
      d_neg     = d_in[SPAN_W-1];
      d_abs     = d_neg ? -d_in : d_in;
      bypass_in = (cfg_end_time_ff <= cfg_start_time_ff) || (req_time_now >= cfg_end_time_ff);
      for (int k = 0; k < LAM_STEPS; k++) begin
         dv_step[k] = div_step(dv_rem_ff[k], dv_num_ff[k][LAM_STEPS-1], span_u);
      end
      lam_mag = LAM_W'(dv_num_ff[LAM_STEPS])
                + LAM_W'(dv_side_ff[LAM_STEPS].neg && (|dv_rem_ff[LAM_STEPS]));
      lam_in  = dv_side_ff[LAM_STEPS].neg ? -$signed(lam_mag) : $signed(lam_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAM_STEPS; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
         lm_vld_ff <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= accept;
         for (int k = 0; k < LAM_STEPS; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         lm_vld_ff <= dv_vld_ff[LAM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= '{bypass: bypass_in, neg: d_neg};
         dv_rem_ff[0]  <= '0;
         dv_num_ff[0]  <= {d_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         for (int k = 0; k < LAM_STEPS; k++) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
            dv_rem_ff[k+1]  <= dv_step[k][DATA_W-1:0];
            dv_num_ff[k+1]  <= {dv_num_ff[k][LAM_STEPS-2:0], dv_step[k][DATA_W]};
         end
         lm_side_ff <= '{bypass: dv_side_ff[LAM_STEPS].bypass, lam: lam_in,
                         h: a3c_ff, g: a3x3_ff, ovf: 1'b0};
      end
   end

   // horner chains: g, h, g, h, h
   always_comb begin
      mac_v[0]  = lm_vld_ff;
      mac_si[0] = lm_side_ff;
      for (int k = 0; k < 5; k++) begin
         mac_si[k+1]     = mac_so[k];
         mac_si[k+1].ovf = mac_so[k].ovf || mac_o[k];
      end
      mac_si[1].g = mac_r[0];
      mac_si[2].h = mac_r[1];
      mac_si[3].g = mac_r[2];
      mac_si[4].h = mac_r[3];
      mac_si[5].h = mac_r[4];
   end

   ctg_mac u_mac_g1 (
      .clock(clock), .reset(reset), .en(en), .vld_in(mac_v[0]), .side_in(mac_si[0]),
      .a_in(mac_si[0].g), .c_in(a2x2_ff), .vld_out(mac_v[1]), .side_out(mac_so[0]),
      .r_out(mac_r[0]), .ovf_out(mac_o[0])
   );

   ctg_mac u_mac_h1 (
      .clock(clock), .reset(reset), .en(en), .vld_in(mac_v[1]), .side_in(mac_si[1]),
      .a_in(mac_si[1].h), .c_in(a2c_ff), .vld_out(mac_v[2]), .side_out(mac_so[1]),
      .r_out(mac_r[1]), .ovf_out(mac_o[1])
   );

   ctg_mac u_mac_g2 (
      .clock(clock), .reset(reset), .en(en), .vld_in(mac_v[2]), .side_in(mac_si[2]),
      .a_in(mac_si[2].g), .c_in(a1c_ff), .vld_out(mac_v[3]), .side_out(mac_so[2]),
      .r_out(mac_r[2]), .ovf_out(mac_o[2])
   );

   ctg_mac u_mac_h2 (
      .clock(clock), .reset(reset), .en(en), .vld_in(mac_v[3]), .side_in(mac_si[3]),
      .a_in(mac_si[3].h), .c_in(a1c_ff), .vld_out(mac_v[4]), .side_out(mac_so[3]),
      .r_out(mac_r[3]), .ovf_out(mac_o[3])
   );

   ctg_mac u_mac_h3 (
      .clock(clock), .reset(reset), .en(en), .vld_in(mac_v[4]), .side_in(mac_si[4]),
      .a_in(mac_si[4].h), .c_in(p0_wide), .vld_out(mac_v[5]), .side_out(mac_so[4]),
      .r_out(mac_r[4]), .ovf_out(mac_o[4])
   );

   // velocity range check and divider
   always_comb begin
      vg     = mac_si[5].g;
      vg_neg = vg[WIDE_W-1];
      vg_big = (vg >= G_LIM) || (vg <= -G_LIM);
      vg_mag = vg_neg ? -vg : vg;
      vg_sh  = vg_mag << FRAC_BITS;
      for (int k = 0; k < VEL_STEPS; k++) begin
         vd_step[k] = div_step(vd_rem_ff[k], vd_num_ff[k][DATA_W-1], span_u);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= VEL_STEPS; k++) begin
            vd_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd_vld_ff[0] <= mac_v[5];
         for (int k = 0; k < VEL_STEPS; k++) begin
            vd_vld_ff[k+1] <= vd_vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vd_side_ff[0] <= '{bypass: mac_si[5].bypass, neg: vg_neg,
                            big: vg_big || (vg_sh[WIDE_W-1:DATA_W] >= span_u),
                            h: mac_si[5].h, ovf: mac_si[5].ovf};
         vd_rem_ff[0]  <= vg_sh[WIDE_W-1:DATA_W];
         vd_num_ff[0]  <= vg_sh[DATA_W-1:0];
         for (int k = 0; k < VEL_STEPS; k++) begin
            vd_side_ff[k+1] <= vd_side_ff[k];
            vd_rem_ff[k+1]  <= vd_step[k][DATA_W-1:0];
            vd_num_ff[k+1]  <= {vd_num_ff[k][DATA_W-2:0], vd_step[k][DATA_W]};
         end
      end
   end

   // output saturation and end-of-span select
   always_comb begin
      vo     = vd_side_ff[VEL_STEPS];
      vq     = vd_num_ff[VEL_STEPS];
      vc     = {1'b0, vq} + (DATA_W+1)'(|vd_rem_ff[VEL_STEPS]);
      vc_neg = -vc;
      ovf_in = vo.ovf;
      if (vo.h > WIDE_W'(S32_MAX)) begin
         pos_in = S32_MAX;
         ovf_in = 1'b1;
      end else if (vo.h < WIDE_W'(S32_MIN)) begin
         pos_in = S32_MIN;
         ovf_in = 1'b1;
      end else begin
         pos_in = vo.h[DATA_W-1:0];
      end
      if (vo.big) begin
         vel_in = vo.neg ? S32_MIN : S32_MAX;
         ovf_in = 1'b1;
      end else if (!vo.neg) begin
         if (vq[DATA_W-1]) begin
            vel_in = S32_MAX;
            ovf_in = 1'b1;
         end else begin
            vel_in = vq;
         end
      end else if (vc > NEG_LIMIT) begin
         vel_in = S32_MIN;
         ovf_in = 1'b1;
      end else begin
         vel_in = vc_neg[DATA_W-1:0];
      end
      if (vo.bypass) begin
         pos_in = cfg_end_position_ff;
         vel_in = cfg_end_velocity_ff;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_vld_ff[VEL_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_position_ff <= pos_in;
         rsp_velocity_ff <= vel_in;
         rsp_overflow_ff <= ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_velocity = rsp_velocity_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

FILE: rtl/ctg_mac.sv
// pipelined multiply by lambda, floor scaling, 64-bit saturation and saturating add
// depends on ctg_pkg
module ctg_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              vld_in,
   input  ctg_pkg::ctg_side_type             side_in,
   input  logic signed [ctg_pkg::WIDE_W-1:0] a_in,
   input  logic signed [ctg_pkg::WIDE_W-1:0] c_in,
   output logic                              vld_out,
   output ctg_pkg::ctg_side_type             side_out,
   output logic signed [ctg_pkg::WIDE_W-1:0] r_out,
   output logic                              ovf_out
);
   import ctg_pkg::*;

   logic [4:0]              vld_ff;
   ctg_side_type            side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic signed [LL_W-1:0]  pp_ll_ff;
   logic signed [LH_W-1:0]  pp_lh_ff;
   logic signed [HL_W-1:0]  pp_hl_ff;
   logic signed [HH_W-1:0]  pp_hh_ff;
   logic signed [LL_W-1:0]  ll2_ff;
   logic signed [HH_W-1:0]  hh2_ff;
   logic signed [MID_W-1:0] mid_ff;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic                     ovf4_ff;
   logic signed [WIDE_W-1:0] r_ff;
   logic                     ovf5_ff;

   logic signed [HALF_W:0]     a_lo;
   logic signed [HALF_W-1:0]   a_hi;
   logic signed [HALF_W:0]     l_lo;
   logic signed [LAM_HI_W-1:0] l_hi;
   logic signed [PROD_W-1:0]   q_in;
   logic                       fits_in;
   logic signed [WIDE_W-1:0]   prod_in;
   logic signed [WIDE_W:0]     sum_in;
   logic signed [WIDE_W-1:0]   r_in;
   logic                       sat_in;

   always_comb begin
      a_lo    = $signed({1'b0, a_in[HALF_W-1:0]});
      a_hi    = $signed(a_in[WIDE_W-1:HALF_W]);
      l_lo    = $signed({1'b0, side_in.lam[HALF_W-1:0]});
      l_hi    = $signed(side_in.lam[LAM_W-1:HALF_W]);
      q_in    = p_ff >>> FRAC_BITS;
      fits_in = (&q_in[PROD_W-1:WIDE_W-1]) || !(|q_in[PROD_W-1:WIDE_W-1]);
      if (fits_in) begin
         prod_in = q_in[WIDE_W-1:0];
      end else if (q_in[PROD_W-1]) begin
         prod_in = S64_MIN;
      end else begin
         prod_in = S64_MAX;
      end
      sum_in = (WIDE_W+1)'(c_in) + (WIDE_W+1)'(prod_ff);
      sat_in = sum_in[WIDE_W] != sum_in[WIDE_W-1];
      if (!sat_in) begin
         r_in = sum_in[WIDE_W-1:0];
      end else if (sum_in[WIDE_W]) begin
         r_in = S64_MIN;
      end else begin
         r_in = S64_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= a_lo * l_lo;
         pp_lh_ff <= a_lo * l_hi;
         pp_hl_ff <= a_hi * l_lo;
         pp_hh_ff <= a_hi * l_hi;
         side1_ff <= side_in;
         mid_ff   <= MID_W'(pp_lh_ff) + MID_W'(pp_hl_ff);
         ll2_ff   <= pp_ll_ff;
         hh2_ff   <= pp_hh_ff;
         side2_ff <= side1_ff;
         p_ff     <= PROD_W'(ll2_ff) + (PROD_W'(mid_ff) <<< HALF_W)
                     + (PROD_W'(hh2_ff) <<< WIDE_W);
         side3_ff <= side2_ff;
         prod_ff  <= prod_in;
         ovf4_ff  <= !fits_in;
         side4_ff <= side3_ff;
         r_ff     <= r_in;
         ovf5_ff  <= ovf4_ff || sat_in;
         side5_ff <= side4_ff;
      end
   end

   assign vld_out  = vld_ff[4];
   assign side_out = side5_ff;
   assign r_out    = r_ff;
   assign ovf_out  = ovf5_ff;

endmodule

FILE: tb/testbench.sv
// testbench for cubic_trajectory_generator_top: drives time words and checks each
// position, velocity and overflow flag against a fixed-point cubic trajectory predictor
// depends on ctg_pkg and the generator rtl
`timescale 1ns / 1ps

module testbench;
   import ctg_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int ITEMS_PER_PROFILE = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = CSR_IDX_W'(7);

   typedef struct {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
      logic                     overflow;
   } traj_point_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [DATA_W-1:0] req_time_now;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [DATA_W-1:0] rsp_position;
   logic signed [DATA_W-1:0] rsp_velocity;
   logic rsp_overflow;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_data;

   logic signed [DATA_W-1:0] traj_regs [6];
   traj_point_type expected_points[$];
   bit gaps_on;
   int error_count;
   int idle_cycles;
   int stall_left;

   cubic_trajectory_generator_top DUT (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // fixed-point product, floored, saturated to 64 bits
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic ovf);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] p;
      wa = a;
      wb = b;
      p = (wa * wb) >>> FRAC_BITS;
      if (p > $signed(S64_MAX)) begin
         ovf = 1'b1;
         return S64_MAX;
      end
      if (p < $signed(S64_MIN)) begin
         ovf = 1'b1;
         return S64_MIN;
      end
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout logic ovf);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         ovf = 1'b1;
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] floor_div(input logic signed [63:0] n,
                                                    input logic signed [63:0] d);
      logic signed [63:0] q;
      q = n / d;
      if (n < 0 && q * d != n) q = q - 1;
      return q;
   endfunction

   function automatic logic signed [31:0] sat_word(input logic signed [63:0] v,
                                                   inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return S32_MAX;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic traj_point_type predict_point(input logic signed [DATA_W-1:0] t_now);
      traj_point_type r;
      logic signed [63:0] t, p0, pf, v0, vf, t0, tf;
      logic signed [63:0] span, lam, dp, a1, a2, a3, h, g, lim;
      logic ovf;
      t = t_now;
      p0 = traj_regs[CSR_START_POSITION];
      pf = traj_regs[CSR_END_POSITION];
      v0 = traj_regs[CSR_START_VELOCITY];
      vf = traj_regs[CSR_END_VELOCITY];
      t0 = traj_regs[CSR_START_TIME];
      tf = traj_regs[CSR_END_TIME];
      ovf = 1'b0;
      if (tf <= t0 || t >= tf) begin
         r.position = pf[31:0];
         r.velocity = vf[31:0];
         r.overflow = 1'b0;
         return r;
      end
      span = tf - t0;
      lam = floor_div((t - t0) <<< FRAC_BITS, span);
      dp = pf - p0;
      a1 = fx_mul(v0, span, ovf);
      a3 = fx_mul(v0 + vf, span, ovf) - 2 * dp;
      a2 = dp - a1 - a3;
      h = a3;
      h = sat_add(a2, fx_mul(h, lam, ovf), ovf);
      h = sat_add(a1, fx_mul(h, lam, ovf), ovf);
      h = sat_add(p0, fx_mul(h, lam, ovf), ovf);
      r.position = sat_word(h, ovf);
      g = 3 * a3;
      g = sat_add(2 * a2, fx_mul(g, lam, ovf), ovf);
      g = sat_add(a1, fx_mul(g, lam, ovf), ovf);
      lim = 64'sd1 <<< (63 - FRAC_BITS);
      if (g >= lim) begin
         ovf = 1'b1;
         r.velocity = S32_MAX;
      end else if (g <= -lim) begin
         ovf = 1'b1;
         r.velocity = S32_MIN;
      end else begin
         r.velocity = sat_word(floor_div(g <<< FRAC_BITS, span), ovf);
      end
      r.overflow = ovf;
      return r;
   endfunction

   task automatic send_time(input logic signed [DATA_W-1:0] t);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_now <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_points.push_back(predict_point(t));
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= CSR_END_TIME) traj_regs[idx] = value;
   endtask

   task automatic load_profile(input logic signed [DATA_W-1:0] p0, pf, v0, vf, t0, tf);
      drain_points();
      write_reg(CSR_START_POSITION, p0);
      write_reg(CSR_END_POSITION, pf);
      write_reg(CSR_START_VELOCITY, v0);
      write_reg(CSR_END_VELOCITY, vf);
      write_reg(CSR_START_TIME, t0);
      write_reg(CSR_END_TIME, tf);
      // coefficients settle after the last write, before the next time word
      repeat (8) @(posedge clock);
   endtask

   task automatic test_reset_profile();
      send_time(0);
      send_time(32'sh0000_8000);
      send_time(32'sh0001_0000);
      send_time(-32'sh0001_0000);
      send_time(S32_MAX);
      send_time(S32_MIN);
   endtask

   task automatic test_directed();
      load_profile(32'sh0001_0000, 32'sh000A_0000, 32'sh0000_8000, -32'sh0000_4000,
                   32'sh0002_0000, 32'sh0006_0000);
      send_time(32'sh0002_0000);
      send_time(32'sh0003_8000);
      send_time(32'sh0005_FFFF);
      send_time(32'sh0006_0000);
      send_time(-32'sh0004_0000);
      send_time(S32_MIN);
      send_time(S32_MAX);
      // degenerate span, end at or before start
      load_profile(32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0007_0000,
                   32'sh0004_0000, 32'sh0004_0000);
      send_time(0);
      send_time(S32_MIN);
      load_profile(32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0007_0000,
                   S32_MAX, S32_MIN);
      send_time(32'sh1234_5678);
      // extremes drive saturation
      load_profile(S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MAX);
      send_time(0);
      send_time(-32'sh4000_0000);
      send_time(S32_MAX - 1);
      send_time(S32_MIN);
      load_profile(S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MAX);
      send_time(0);
      send_time(32'sh7000_0000);
      send_time(S32_MIN);
      // unused register indexes leave the profile untouched
      drain_points();
      write_reg(CSR_UNUSED_A, 32'hFFFF_FFFF);
      write_reg(CSR_UNUSED_B, 32'h1234_5678);
      repeat (8) @(posedge clock);
      send_time(32'sh0000_0001);
      send_time(32'sh4000_0000);
   endtask

   task automatic test_random();
      logic signed [DATA_W-1:0] p[6];
      logic signed [63:0] lo, hi, t;
      logic [63:0] width;
      int kind;
      for (int n = 0; n < 12; n++) begin
         kind = $urandom_range(0, 9);
         for (int i = 0; i < 6; i++) p[i] = $urandom;
         if (kind < 6) begin
            for (int i = 0; i < 4; i++) p[i] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            p[CSR_START_TIME] = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            p[CSR_END_TIME] = p[CSR_START_TIME] + $urandom_range(1, 32'h00FF_FFFF);
         end else if (kind < 9 && p[CSR_END_TIME] < p[CSR_START_TIME]) begin
            p[CSR_START_TIME] = p[CSR_END_TIME];
            p[CSR_END_TIME] = $urandom;
         end
         gaps_on = (n % 4) != 3;
         load_profile(p[0], p[1], p[2], p[3], p[4], p[5]);
         lo = traj_regs[CSR_START_TIME];
         hi = traj_regs[CSR_END_TIME];
         if (hi > lo) begin
            width = hi - lo;
            lo = lo - (width >>> 3);
            hi = hi + (width >>> 4);
            if (lo < -64'sd2147483648) lo = -64'sd2147483648;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
         end
         width = hi - lo + 1;
         for (int i = 0; i < ITEMS_PER_PROFILE; i++) begin
            if ($urandom_range(0, 4) == 0 || width == 0) begin
               send_time($urandom);
            end else begin
               t = lo + $signed({$urandom, $urandom} % width);
               send_time(t[31:0]);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      traj_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected word pos %0d vel %0d ovf %0d", $time,
                     rsp_position, rsp_velocity, rsp_overflow);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_position !== want.position) begin
               $display("%0t: position expected %0d actual %0d", $time,
                        want.position, rsp_position);
               error_count++;
            end
            if (rsp_velocity !== want.velocity) begin
               $display("%0t: velocity expected %0d actual %0d", $time,
                        want.velocity, rsp_velocity);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0d actual %0d", $time,
                        want.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      int next_stall;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= (stall_left == 0);
      end else if (rsp_valid && rsp_ready) begin
         next_stall = gaps_on ? $urandom_range(0, 10) : 0;
         stall_left = next_stall;
         rsp_ready <= (next_stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      stall_left = 0;
      idle_cycles = 0;
      gaps_on = 1'b1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_time_now <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      for (int i = 0; i < 6; i++) traj_regs[i] = '0;
      traj_regs[CSR_END_TIME] = END_TIME_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_profile();
      test_directed();
      test_random();
      drain_points();
      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/ctg_pkg.sv
rtl/ctg_mac.sv
rtl/cubic_trajectory_generator_top.sv
tb/testbench.sv
